// ===== hdl/qmeu_pkg.sv =====
// qmeu_pkg: shared types and constants of the queue machine execute unit
// used by qmeu_divider and queue_machine_execute_unit
package qmeu_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int NUM_REGS    = 26;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int RA_W        = 5;
  localparam int WORD_W      = 16;

  localparam logic [4:0] CMD_PUSH   = 5'd0;
  localparam logic [4:0] CMD_ADD    = 5'd1;
  localparam logic [4:0] CMD_SUB    = 5'd2;
  localparam logic [4:0] CMD_MUL    = 5'd3;
  localparam logic [4:0] CMD_DIV    = 5'd4;
  localparam logic [4:0] CMD_MOD    = 5'd5;
  localparam logic [4:0] CMD_STORE  = 5'd6;
  localparam logic [4:0] CMD_LOAD   = 5'd7;
  localparam logic [4:0] CMD_PRQ    = 5'd8;
  localparam logic [4:0] CMD_PRR    = 5'd9;
  localparam logic [4:0] CMD_CHQ    = 5'd10;
  localparam logic [4:0] CMD_CHR    = 5'd11;
  localparam logic [4:0] CMD_NOP    = 5'd12;
  localparam logic [4:0] CMD_JUMP   = 5'd13;
  localparam logic [4:0] CMD_JZ     = 5'd14;
  localparam logic [4:0] CMD_JEQ    = 5'd15;
  localparam logic [4:0] CMD_JGT    = 5'd16;
  localparam logic [4:0] CMD_QUIT   = 5'd17;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_UNDER = 2'd1;
  localparam logic [1:0] FLT_OVER  = 2'd2;

  typedef struct packed {
    logic [4:0]        cmd;
    logic [4:0]        reg_first;
    logic [4:0]        reg_second;
    logic [WORD_W-1:0] immediate;
  } qmeu_in_t;

  typedef struct packed {
    logic              print_valid;
    logic [WORD_W-1:0] print_value;
    logic              print_as_char;
    logic              branch_taken;
    logic              halted;
    logic [1:0]        fault;
  } qmeu_out_t;

  // divider control and status
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } qmeu_div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } qmeu_div_rsp_t;

endpackage

// ===== hdl/qmeu_divider.sv =====
// qmeu_divider: unsigned 16-bit restoring divider, one quotient bit per cycle
// depends on qmeu_pkg
module qmeu_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qmeu_pkg::qmeu_div_req_t req,
  output qmeu_pkg::qmeu_div_rsp_t rsp
);
  import qmeu_pkg::*;

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] dvs_r;
  logic              done_r;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   shifted;

  // one shift and subtract step
  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(WORD_W);
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        if (trial[WORD_W]) begin
          rem_r <= shifted[WORD_W-1:0];
          quo_r <= {quo_r[WORD_W-2:0], 1'b0};
        end else begin
          rem_r <= trial[WORD_W-1:0];
          quo_r <= {quo_r[WORD_W-2:0], 1'b1};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== hdl/queue_machine_execute_unit.sv =====
// queue_machine_execute_unit: executes one decoded queue machine instruction per word
// depends on qmeu_pkg and qmeu_divider
//
//   channel | ports                        | dir | word
//   input   | in_valid in_stall in_data    | in  | qmeu_in_t (cmd, regs, immediate)
//   result  | out_valid out_stall out_data | out | qmeu_out_t (print, branch, halt, fault)
//
// one instruction at a time; push, load, quit, faults and ignored words have their
// result registered at the accepting edge; register, jump, store and queue print
// words pass through S_DONE; add, sub and mul through S_POP1 and S_ARITH (one queue
// memory read per pop); div and mod go on to S_DIV for 16 bit-serial divider steps.
// rst_n synchronously clears pointers, count, halt and the register valid bits.
// a result waits in the output register while out_stall is high; the next word
// is taken the cycle after that register is freed.
module queue_machine_execute_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qmeu_pkg::qmeu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qmeu_pkg::qmeu_out_t out_data
);
  import qmeu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_POP1, S_ARITH, S_DIV, S_DONE
  } state_t;

  state_t            state_r;
  qmeu_in_t          ins_r;
  logic [QA_W-1:0]   head_r;
  logic [QA_W-1:0]   tail_r;
  logic [QC_W-1:0]   count_r;
  logic              halt_r;
  logic [WORD_W-1:0] regs_r [NUM_REGS];
  logic [NUM_REGS-1:0] rvalid_r;
  logic [WORD_W-1:0] qmem [QUEUE_DEPTH];
  logic [WORD_W-1:0] qrd_r;
  logic [WORD_W-1:0] opa_r;
  logic              out_valid_r;
  qmeu_out_t         out_r;
  qmeu_out_t         out_nxt;
  qmeu_div_req_t     dreq;
  qmeu_div_rsp_t     drsp;

  logic              qwe;
  logic [WORD_W-1:0] qwd;
  logic [QA_W-1:0]   qra;

  // register file reads, out-of-range and never-written entries read zero
  function automatic logic [WORD_W-1:0] rd(input logic [4:0] idx,
      input logic [NUM_REGS-1:0] vb, input logic [WORD_W-1:0] rf [NUM_REGS]);
    logic [WORD_W-1:0] v;
    v = '0;
    if (idx < RA_W'(NUM_REGS) && vb[idx]) v = rf[idx];
    return v;
  endfunction

  function automatic logic [QA_W-1:0] inc(input logic [QA_W-1:0] p);
    logic [QA_W-1:0] n;
    n = (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  logic [WORD_W-1:0] r1v, r2v;
  assign r1v = rd(ins_r.reg_first, rvalid_r, regs_r);
  assign r2v = rd(ins_r.reg_second, rvalid_r, regs_r);

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // queue memory read port, head address or, in S_POP1, the entry after head
  assign qra = (state_r == S_POP1) ? inc(head_r) : head_r;
  always_ff @(posedge clk) begin
    qrd_r <= qmem[qra];
    if (qwe) qmem[tail_r] <= qwd;
  end

  // arithmetic result and push source
  logic [31:0] prod;
  assign prod = {16'd0, opa_r} * {16'd0, qrd_r};
  always_comb begin
    qwe = 1'b0;
    qwd = '0;
    if (state_r == S_IDLE && !halt_r && in_valid && !in_stall &&
        (in_data.cmd == CMD_PUSH || in_data.cmd == CMD_LOAD) &&
        count_r < QC_W'(QUEUE_DEPTH)) begin
      qwe = 1'b1;
      qwd = (in_data.cmd == CMD_PUSH) ? in_data.immediate :
            rd(in_data.reg_first, rvalid_r, regs_r);
    end else if (state_r == S_ARITH && ins_r.cmd != CMD_DIV && ins_r.cmd != CMD_MOD) begin
      qwe = 1'b1;
      case (ins_r.cmd)
        CMD_ADD: qwd = opa_r + qrd_r;
        CMD_SUB: qwd = opa_r - qrd_r;
        default: qwd = prod[WORD_W-1:0];
      endcase
    end else if (state_r == S_DIV && drsp.done) begin
      qwe = 1'b1;
      if (opa_r == '0) qwd = '0; // opa holds divisor here
      else qwd = (ins_r.cmd == CMD_DIV) ? drsp.quotient : drsp.remainder;
    end
  end

  // result word of the word being accepted or of the word being finished
  always_comb begin
    out_nxt = '0;
    if (state_r == S_IDLE) begin
      if (halt_r) out_nxt.halted = 1'b1;
      else begin
        case (in_data.cmd)
          CMD_PUSH, CMD_LOAD: begin
            if (count_r >= QC_W'(QUEUE_DEPTH)) out_nxt.fault = FLT_OVER;
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
            if (count_r < QC_W'(2)) out_nxt.fault = FLT_UNDER;
          end
          CMD_STORE, CMD_PRQ, CMD_CHQ: begin
            if (count_r == '0) out_nxt.fault = FLT_UNDER;
          end
          CMD_QUIT: out_nxt.halted = 1'b1;
          default: ;
        endcase
      end
    end else begin
      case (ins_r.cmd)
        CMD_PRQ, CMD_CHQ: begin
          out_nxt.print_valid   = 1'b1;
          out_nxt.print_value   = qrd_r;
          out_nxt.print_as_char = (ins_r.cmd == CMD_CHQ);
        end
        CMD_PRR, CMD_CHR: begin
          out_nxt.print_valid   = 1'b1;
          out_nxt.print_value   = r1v;
          out_nxt.print_as_char = (ins_r.cmd == CMD_CHR);
        end
        CMD_JUMP: out_nxt.branch_taken = 1'b1;
        CMD_JZ:   out_nxt.branch_taken = (r1v == '0);
        CMD_JEQ:  out_nxt.branch_taken = (r1v == r2v);
        CMD_JGT:  out_nxt.branch_taken = (r1v > r2v);
        default: ;
      endcase
    end
  end

  assign dreq.start    = (state_r == S_ARITH) && (ins_r.cmd == CMD_DIV || ins_r.cmd == CMD_MOD);
  assign dreq.dividend = opa_r;
  assign dreq.divisor  = qrd_r;

  qmeu_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // sequencer, pointers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      halt_r      <= 1'b0;
      rvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (qwe) begin
        tail_r <= inc(tail_r);
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            ins_r <= in_data;
            out_r <= out_nxt;
            if (halt_r) begin
              out_valid_r <= 1'b1;
            end else begin
              case (in_data.cmd)
                CMD_PUSH, CMD_LOAD: begin
                  if (count_r < QC_W'(QUEUE_DEPTH)) count_r <= count_r + 1'b1;
                  out_valid_r <= 1'b1;
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                  if (count_r < QC_W'(2)) out_valid_r <= 1'b1;
                  else state_r <= S_POP1;
                end
                CMD_STORE, CMD_PRQ, CMD_CHQ: begin
                  if (count_r == '0) out_valid_r <= 1'b1;
                  else state_r <= S_DONE;
                end
                CMD_PRR, CMD_CHR, CMD_JUMP, CMD_JZ, CMD_JEQ, CMD_JGT: state_r <= S_DONE;
                CMD_QUIT: begin
                  halt_r      <= 1'b1;
                  out_valid_r <= 1'b1;
                end
                default: out_valid_r <= 1'b1;
              endcase
            end
          end
        end
        // first operand captured, second one is read this cycle
        S_POP1: begin
          opa_r   <= qrd_r;
          head_r  <= inc(inc(head_r));
          count_r <= count_r - QC_W'(1);
          state_r <= S_ARITH;
        end
        S_ARITH: begin
          if (dreq.start) begin
            opa_r   <= qrd_r;
            state_r <= S_DIV;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
          out_r       <= out_nxt;
          case (ins_r.cmd)
            CMD_STORE: begin
              head_r  <= inc(head_r);
              count_r <= count_r - 1'b1;
              if (ins_r.reg_first < RA_W'(NUM_REGS)) begin
                regs_r[ins_r.reg_first]   <= qrd_r;
                rvalid_r[ins_r.reg_first] <= 1'b1;
              end
            end
            CMD_PRQ, CMD_CHQ: begin
              head_r  <= inc(head_r);
              count_r <= count_r - 1'b1;
            end
            default: ;
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
